// ===== design/ieval_pkg.sv =====
// Shared types and constants for the infix integer expression evaluator.
// Used by the front, queue, arithmetic unit, back and top level; depends on nothing.
`default_nettype none

package ieval_pkg;

  localparam int WORD_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int TOK_BITS        = 3;
  localparam int RESULT_BITS     = 32;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic REG_SKIP_CHAR = 1'b0;

  typedef enum logic [TOK_BITS-1:0] {
    TOK_MUL = 3'd0,
    TOK_DIV = 3'd1,
    TOK_ADD = 3'd2,
    TOK_SUB = 3'd3,
    TOK_EQ  = 3'd4
  } tok_op_t;

  typedef enum logic [1:0] {
    MOP_FIRST = 2'd0,
    MOP_MUL   = 2'd1,
    MOP_DIV   = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic dz;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== design/ieval_front.sv =====
// Front end: accepts characters, drops the skip character, builds decimal numbers
// and pushes one operator item with its operand into the queue. Depends on ieval_pkg.
`default_nettype none

module ieval_front #(
  parameter int WORD_BITS = ieval_pkg::WORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [7:0]                        char_in,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        skip_char,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output logic [ieval_pkg::TOK_BITS+WORD_BITS-1:0] q_wdata
);
  import ieval_pkg::*;

  logic [WORD_BITS-1:0] number;
  logic [WORD_BITS-1:0] number_next;
  logic                 closed;
  logic                 closed_next;
  logic                 accept;
  logic                 is_skip;
  logic                 is_digit;
  logic                 is_op;
  tok_op_t              op;
  logic [7:0]           dval;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_skip  = (char_in == skip_char);
  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign dval     = char_in - CH_ZERO;

  always_comb begin
    is_op = 1'b1;
    op    = TOK_EQ;
    unique case (char_in)
      CH_MUL:   op = TOK_MUL;
      CH_DIV:   op = TOK_DIV;
      CH_PLUS:  op = TOK_ADD;
      CH_MINUS: op = TOK_SUB;
      CH_EQ:    op = TOK_EQ;
      default:  is_op = 1'b0;
    endcase
  end

  always_comb begin
    number_next = number;
    closed_next = closed;
    q_push      = 1'b0;
    if (accept && !is_skip) begin
      if (is_digit) begin
        if (!closed) begin
          number_next = (number << 3) + (number << 1)
                        + {{(WORD_BITS-4){1'b0}}, dval[3:0]};
        end
      end else if (is_op) begin
        q_push      = 1'b1;
        number_next = '0;
        closed_next = 1'b0;
      end else begin
        closed_next = 1'b1;
      end
    end
  end

  assign q_wdata = {op, number};

  always_ff @(posedge clk) begin
    if (rst) begin
      number <= '0;
      closed <= 1'b0;
    end else begin
      number <= number_next;
      closed <= closed_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/ieval_queue.sv =====
// Short first-in first-out queue of operator items between front and back.
// Show-ahead read port. Depends on ieval_pkg for its default width and depth.
`default_nettype none

module ieval_queue #(
  parameter int WIDTH = ieval_pkg::TOK_BITS + ieval_pkg::WORD_BITS_DEF,
  parameter int DEPTH = ieval_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  full,
  output logic                  empty
);
  import ieval_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ieval_alu.sv =====
// Iterative arithmetic unit: shift-and-add multiply and restoring signed divide,
// one bit per cycle. Depends on ieval_pkg for the request and response structs.
`default_nettype none

module ieval_alu #(
  parameter int WORD_BITS = ieval_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ieval_pkg::alu_req_t  req,
  input  wire logic [WORD_BITS-1:0] opa_in,
  input  wire logic [WORD_BITS-1:0] opb_in,
  output ieval_pkg::alu_rsp_t       rsp,
  output logic [WORD_BITS-1:0]      result
);
  import ieval_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_RUN  = 3'b010,
    A_FIX  = 3'b100
  } alu_state_t;

  alu_state_t    state;
  logic          mode_div;
  logic          neg;
  logic          dz;
  logic [W-1:0]  acc;
  logic [W-1:0]  opa;
  logic [W-1:0]  opb;
  logic [W-1:0]  rem;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem_sh;
  logic          ge;
  logic          na;
  logic          nb;
  logic [W-1:0]  ua;
  logic [W-1:0]  ub;

  assign na     = opa_in[W-1];
  assign nb     = opb_in[W-1];
  assign ua     = na ? (~opa_in + 1'b1) : opa_in;
  assign ub     = nb ? (~opb_in + 1'b1) : opb_in;
  assign rem_sh = {rem[W-2:0], opa[W-1]};
  assign ge     = (rem_sh >= opb);

  assign rsp.busy = (state != A_IDLE);
  assign rsp.done = (state == A_FIX);
  assign rsp.dz   = dz;
  assign result   = neg ? (~acc + 1'b1) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            cnt <= CW'(W);
            if (req.is_div && (ub == '0)) begin
              state <= A_FIX;
            end else begin
              state <= A_RUN;
            end
          end
        end
        A_RUN: begin
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == A_IDLE && req.start) begin
      mode_div <= req.is_div;
      acc      <= '0;
      rem      <= '0;
      if (req.is_div) begin
        opa <= ua;
        opb <= ub;
        neg <= (na != nb) && (ub != '0);
        dz  <= (ub == '0);
      end else begin
        opa <= opa_in;
        opb <= opb_in;
        neg <= 1'b0;
        dz  <= 1'b0;
      end
    end else if (state == A_RUN) begin
      opa <= opa << 1;
      if (mode_div) begin
        acc <= {acc[W-2:0], ge};
        rem <= ge ? (rem_sh - opb) : rem_sh;
      end else begin
        opb <= opb >> 1;
        if (opb[0]) begin
          acc <= acc + opa;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ieval_back.sv =====
// Back end: takes operator items from the queue, folds operands into the running
// term and sum, and registers the result on '='. Depends on ieval_pkg.
`default_nettype none

module ieval_back #(
  parameter int WORD_BITS = ieval_pkg::WORD_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    q_empty,
  input  wire logic [ieval_pkg::TOK_BITS+WORD_BITS-1:0] q_rdata,
  output logic                                         q_pop,
  output ieval_pkg::alu_req_t                          alu_req,
  output logic [WORD_BITS-1:0]                         alu_opa,
  output logic [WORD_BITS-1:0]                         alu_opb,
  input  wire ieval_pkg::alu_rsp_t                     alu_rsp,
  input  wire logic [WORD_BITS-1:0]                    alu_result,
  output logic signed [ieval_pkg::RESULT_BITS-1:0]     result_value,
  output logic                                         div_by_zero,
  output logic                                         out_valid,
  input  wire logic                                    out_stall
);
  import ieval_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_CALC = 3'b010,
    B_FIN  = 3'b100
  } back_state_t;

  back_state_t          state;
  logic [WORD_BITS-1:0] sum;
  logic [WORD_BITS-1:0] term;
  mul_op_t              mul_op;
  logic                 sign_minus;
  logic                 err;
  tok_op_t              tok_op;
  logic                 out_free;
  logic                 emit_eq;
  logic [WORD_BITS-1:0] sum_next;
  tok_op_t              head_op;
  logic [WORD_BITS-1:0] head_num;

  assign head_op  = tok_op_t'(q_rdata[WORD_BITS +: TOK_BITS]);
  assign head_num = q_rdata[WORD_BITS-1:0];
  assign out_free = !out_valid || !out_stall;
  assign emit_eq  = (state == B_FIN) && (tok_op == TOK_EQ) && out_free;
  assign sum_next = sign_minus ? (sum - term) : (sum + term);

  assign q_pop          = (state == B_IDLE) && !q_empty;
  assign alu_req.start  = q_pop && (mul_op != MOP_FIRST);
  assign alu_req.is_div = (mul_op == MOP_DIV);
  assign alu_opa        = term;
  assign alu_opb        = head_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      sum        <= '0;
      term       <= '0;
      mul_op     <= MOP_FIRST;
      sign_minus <= 1'b0;
      err        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit_eq) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            tok_op <= head_op;
            if (mul_op == MOP_FIRST) begin
              term  <= head_num;
              state <= B_FIN;
            end else begin
              state <= B_CALC;
            end
          end
        end
        B_CALC: begin
          if (alu_rsp.done) begin
            term  <= alu_result;
            err   <= err || alu_rsp.dz;
            state <= B_FIN;
          end
        end
        B_FIN: begin
          unique case (tok_op)
            TOK_MUL: begin
              mul_op <= MOP_MUL;
              state  <= B_IDLE;
            end
            TOK_DIV: begin
              mul_op <= MOP_DIV;
              state  <= B_IDLE;
            end
            TOK_ADD, TOK_SUB: begin
              sum        <= sum_next;
              term       <= '0;
              mul_op     <= MOP_FIRST;
              sign_minus <= (tok_op == TOK_SUB);
              state      <= B_IDLE;
            end
            TOK_EQ: begin
              if (out_free) begin
                result_value <= RESULT_BITS'($signed(sum_next));
                div_by_zero  <= err;
                out_valid    <= 1'b1;
                sum          <= '0;
                term         <= '0;
                mul_op       <= MOP_FIRST;
                sign_minus   <= 1'b0;
                err          <= 1'b0;
                state        <= B_IDLE;
              end
            end
            default: begin
              state <= B_IDLE;
            end
          endcase
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/infix_integer_expression_evaluator.sv =====
// Top level of the infix integer expression evaluator: configuration port, front,
// queue, back and arithmetic unit. Depends on ieval_pkg and all ieval_* modules.
//
// Characters enter on char_in, one per cycle while in_stall is low; in_stall rises
// only when the operator queue (QUEUE_DEPTH items) is full. Digits, the skip
// character and other characters are handled in the front end alone. Each
// operator or '=' becomes a queue item; the back end takes an item whose operand
// needs no multiply or divide from B_IDLE to B_FIN, and one that follows '*' or
// '/' through B_IDLE, B_CALC and B_FIN, where B_CALC waits on the one-bit-per-cycle
// shift-and-add multiplier and restoring divider. The result of '=' waits in an
// output register.
`default_nettype none

module infix_integer_expression_evaluator #(
  parameter int WORD_BITS   = ieval_pkg::WORD_BITS_DEF,
  parameter int QUEUE_DEPTH = ieval_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [7:0]                          char_in,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  output logic signed [ieval_pkg::RESULT_BITS-1:0] result_value,
  output logic                                     div_by_zero,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import ieval_pkg::*;

  localparam int QW = TOK_BITS + WORD_BITS;

  logic [7:0]           skip_char;
  logic                 cfg_write;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;
  logic [WORD_BITS-1:0] alu_opa;
  logic [WORD_BITS-1:0] alu_opb;
  logic [WORD_BITS-1:0] alu_result;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_SKIP_CHAR) ? {24'd0, skip_char} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_char <= CH_SPACE;
    end else if (cfg_write && (paddr[2] == REG_SKIP_CHAR)) begin
      skip_char <= pwdata[7:0];
    end
  end

  ieval_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .skip_char (skip_char),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  ieval_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ieval_alu #(.WORD_BITS(WORD_BITS)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa_in (alu_opa),
    .opb_in (alu_opb),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  ieval_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .alu_req      (alu_req),
    .alu_opa      (alu_opa),
    .alu_opb      (alu_opb),
    .alu_rsp      (alu_rsp),
    .alu_result   (alu_result),
    .result_value (result_value),
    .div_by_zero  (div_by_zero),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("operator item pushed into a full queue");

  a_alu_start_idle: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_rsp.busy)
    else $error("arithmetic unit started while busy");

  a_alu_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(alu_rsp.done) |-> $past(alu_rsp.busy || alu_req.start))
    else $error("arithmetic unit finished without being started");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire
